// File: src/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg: shared types and constants for the equal range random pick block
// Holds the input and result beat structs, status codes and table sizing.
// ----------------------------------------------------------------------------
package erp_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned PosW          = 10;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned RandW         = 31;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2
  } status_e;

  typedef enum logic {
    ModeLoad = 1'b0,
    ModePick = 1'b1
  } mode_e;

  typedef struct packed {
    logic                     mode;
    logic signed [ValueW-1:0] value;
    logic [RandW-1:0]         random_word;
    logic                     first_of_load;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] picked_position;
    logic [1:0]      status;
  } rsp_t;

endpackage

// File: src/equal_range_random_pick.sv
// ----------------------------------------------------------------------------
// equal_range_random_pick: sorted table with random pick over equal runs
// Loads insert a value in sorted place; picks find the run of equal entries
// by two binary searches and return the load position of a random member.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  request   | in        | start_i high, !busy_o| req_i   (erp_pkg::req_t)
//  result    | out       | done_o strobe, 1 cyc | rsp_o   (erp_pkg::rsp_t)
//
//  each binary search step reads the middle entry, then compares it; a
//  closing read state ends the search. a load then moves each entry above
//  the insert point up one place (memory read, then write). a pick takes
//  two binary searches, a bit-serial modulo of the 31-bit random word and
//  one read. a load into a full table ends at once.
//  reset empties the table at once (count cleared); no clearing pass.
//  busy_o is high from accept through the result strobe; the receiver cannot stall.
module equal_range_random_pick #(
  parameter int unsigned TableDepth = erp_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  erp_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output erp_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned RandW = erp_pkg::RandW;
  localparam int unsigned PosW  = erp_pkg::PosW;

  typedef enum logic [3:0] {
    StIdle, StSrchRd, StSrchCmp, StShRd, StShWr, StIns,
    StModInit, StMod, StPickRd, StPickOut, StDone
  } state_e;

  // table memories, one synchronous read port each
  logic [31:0]     val_mem [TableDepth];
  logic [PosW-1:0] pos_mem [TableDepth];
  logic [31:0]     val_rd_q;
  logic [PosW-1:0] pos_rd_q;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] lo_q, hi_q, first_q, idx_q;
  logic [31:0]     key_q;
  logic            mode_q;
  logic            strict_q;
  logic [RandW-1:0] rnd_q;
  logic [CntW-1:0] len_q, rem_q;
  logic [4:0]      bit_q;
  erp_pkg::rsp_t   rsp_q;
  logic            done_q;

  logic            mem_we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [31:0]     wr_val;
  logic [PosW-1:0] wr_pos;
  logic [CntW-1:0] mid;
  logic [CntW:0]   rem_sh;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign rem_sh = {rem_q, rnd_q[RandW-1]};

  // read address selection per state
  always_comb begin
    case (state_q)
      StSrchRd: rd_addr = mid[AddrW-1:0];
      StShRd:   rd_addr = idx_q[AddrW-1:0] - AddrW'(1);
      default:  rd_addr = idx_q[AddrW-1:0];
    endcase
  end

  // write port: shift one entry up, or drop the new key in place
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q[AddrW-1:0];
    wr_val  = val_rd_q;
    wr_pos  = pos_rd_q;
    if (state_q == StShWr) begin
      mem_we = 1'b1;
    end else if (state_q == StIns) begin
      mem_we = 1'b1;
      wr_val = key_q;
      wr_pos = PosW'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[wr_addr] <= wr_val;
      pos_mem[wr_addr] <= wr_pos;
    end
    val_rd_q <= val_mem[rd_addr];
    pos_rd_q <= pos_mem[rd_addr];
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      done_q   <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      first_q  <= '0;
      idx_q    <= '0;
      key_q    <= '0;
      mode_q   <= 1'b0;
      strict_q <= 1'b0;
      rnd_q    <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      bit_q    <= '0;
      rsp_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i && !busy_o) begin
            key_q  <= {~req_i.value[31], req_i.value[30:0]};
            rnd_q  <= req_i.random_word;
            mode_q <= req_i.mode;
            rsp_q  <= '0;
            lo_q   <= '0;
            if (req_i.mode == erp_pkg::ModeLoad) begin
              if (req_i.first_of_load) begin
                count_q <= '0;
                hi_q    <= '0;
                state_q <= StSrchRd;
              end else if (count_q >= CntW'(TableDepth)) begin
                rsp_q.status <= erp_pkg::StatusFull;
                state_q      <= StDone;
              end else begin
                hi_q    <= count_q;
                state_q <= StSrchRd;
              end
              strict_q <= 1'b1;
            end else begin
              hi_q     <= count_q;
              strict_q <= 1'b0;
              state_q  <= StSrchRd;
            end
          end
        end
        StSrchRd: begin
          if (lo_q < hi_q) state_q <= StSrchCmp;
          else if (mode_q == erp_pkg::ModeLoad) begin
            idx_q   <= count_q;
            state_q <= (count_q > lo_q) ? StShRd : StIns;
          end else if (!strict_q) begin
            first_q  <= lo_q;
            strict_q <= 1'b1;
            hi_q     <= count_q;
          end else if (first_q >= lo_q) begin
            rsp_q.status <= erp_pkg::StatusNotFound;
            state_q      <= StDone;
          end else begin
            len_q   <= lo_q - first_q;
            state_q <= StModInit;
          end
        end
        StSrchCmp: begin
          if (strict_q ? (val_rd_q <= key_q) : (val_rd_q < key_q)) lo_q <= mid + CntW'(1);
          else hi_q <= mid;
          state_q <= StSrchRd;
        end
        StShRd: state_q <= StShWr;
        StShWr: begin
          idx_q   <= idx_q - CntW'(1);
          state_q <= (idx_q - CntW'(1) > lo_q) ? StShRd : StIns;
        end
        StIns: begin
          count_q <= count_q + CntW'(1);
          state_q <= StDone;
        end
        StModInit: begin
          rem_q   <= '0;
          bit_q   <= 5'(RandW - 1);
          state_q <= StMod;
        end
        // restoring remainder, one random bit a cycle
        StMod: begin
          if (rem_sh >= {1'b0, len_q}) rem_q <= CntW'(rem_sh - {1'b0, len_q});
          else rem_q <= rem_sh[CntW-1:0];
          rnd_q <= rnd_q << 1;
          bit_q <= bit_q - 5'd1;
          if (bit_q == '0) state_q <= StPickRd;
        end
        StPickRd: begin
          idx_q   <= first_q + rem_q;
          state_q <= StPickOut;
        end
        StPickOut: begin
          state_q <= StDone;
        end
        StDone: begin
          if (mode_q == erp_pkg::ModePick && rsp_q.status == erp_pkg::StatusOk) begin
            rsp_q.picked_position <= pos_rd_q;
          end
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: tb/tb_equal_range_random_pick.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_equal_range_random_pick: self-checking bench for the sorted pick table
// Drives load and pick commands, mirrors the sorted table in a local
// predictor and checks every result beat against the expected position and status.
// ----------------------------------------------------------------------------
module tb_equal_range_random_pick;

  localparam int unsigned Depth    = erp_pkg::TableDepthDef;
  localparam int unsigned PosW     = erp_pkg::PosW;
  localparam int unsigned NumRand  = 563;
  localparam longint      MaxCyc   = 64'd8_000_000;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  erp_pkg::req_t req_i;
  logic          busy_o;
  logic          done_o;
  erp_pkg::rsp_t rsp_o;

  // predictor copy of the table
  logic [31:0]     tbl_val [Depth];
  logic [PosW-1:0] tbl_pos [Depth];
  int unsigned     tbl_cnt;

  erp_pkg::rsp_t pending_rsp [$];
  int     err_cnt;
  longint cyc_cnt;
  int     n_load, n_pick, n_full, n_miss;
  bit     no_idle;

  // directed stimulus row; chk marks a typed-in expectation
  typedef struct {
    erp_pkg::req_t req;
    bit            chk;
    erp_pkg::rsp_t rsp;
  } row_t;

  row_t rows [$];

  equal_range_random_pick dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // first index with key >= target, or > target when upper is set
  function automatic int unsigned find_bound(logic [31:0] key, bit upper);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = tbl_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (upper ? (tbl_val[mid] <= key) : (tbl_val[mid] < key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // apply one command to the table copy and return the expected beat
  function automatic erp_pkg::rsp_t pick_predict(erp_pkg::req_t r);
    erp_pkg::rsp_t res;
    logic [31:0]   key;
    int unsigned   at, lo, hi;
    res = '0;
    key = r.value ^ 32'h8000_0000;
    if (r.mode == erp_pkg::ModeLoad) begin
      if (r.first_of_load) tbl_cnt = 0;
      if (tbl_cnt >= Depth) begin
        res.status = erp_pkg::StatusFull;
      end else begin
        at = find_bound(key, 1'b1);
        for (int i = tbl_cnt; i > at; i--) begin
          tbl_val[i] = tbl_val[i-1];
          tbl_pos[i] = tbl_pos[i-1];
        end
        tbl_val[at] = key;
        tbl_pos[at] = tbl_cnt[PosW-1:0];
        tbl_cnt++;
        res.status = erp_pkg::StatusOk;
      end
    end else begin
      lo = find_bound(key, 1'b0);
      hi = find_bound(key, 1'b1);
      if (lo >= hi) res.status = erp_pkg::StatusNotFound;
      else res.picked_position = tbl_pos[lo + r.random_word % (hi - lo)];
    end
    return res;
  endfunction

  // send one command beat; idle burst before it unless quiet
  task automatic send_cmd(erp_pkg::req_t r, bit chk, erp_pkg::rsp_t typed);
    erp_pkg::rsp_t exp_rsp;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    // busy only moves at the rising edge, so it is stable here
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    exp_rsp = pick_predict(r);
    if (chk && exp_rsp !== typed) begin
      $display("%0t: predictor disagrees with table row: exp %h got %h",
               $time, typed, exp_rsp);
      err_cnt++;
    end
    pending_rsp.insert(pending_rsp.size(), chk ? typed : exp_rsp);
    if (r.mode == erp_pkg::ModeLoad) begin
      n_load++;
      if (exp_rsp.status == erp_pkg::StatusFull) n_full++;
    end else begin
      n_pick++;
      if (exp_rsp.status == erp_pkg::StatusNotFound) n_miss++;
    end
    @(negedge clk_i);
  endtask

  function automatic erp_pkg::req_t mk_req(erp_pkg::mode_e m, logic [31:0] v,
                                           logic [30:0] w, bit f);
    erp_pkg::req_t r;
    r.mode          = m;
    r.value         = v;
    r.random_word   = w;
    r.first_of_load = f;
    return r;
  endfunction

  function automatic erp_pkg::rsp_t mk_rsp(logic [PosW-1:0] p, erp_pkg::status_e s);
    erp_pkg::rsp_t x;
    x.picked_position = p;
    x.status          = s;
    return x;
  endfunction

  function automatic void add_row(erp_pkg::req_t q, bit chk, erp_pkg::rsp_t e);
    rows.insert(rows.size(), row_t'{q, chk, e});
  endfunction

  // result checker
  always @(posedge clk_i) begin
    erp_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result beat: exp none got %h", $time, rsp_o);
        err_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.picked_position !== want.picked_position) begin
          $display("%0t: position mismatch: exp %0d got %0d", $time,
                   want.picked_position, rsp_o.picked_position);
          err_cnt++;
        end
        if (rsp_o.status !== want.status) begin
          $display("%0t: status mismatch: exp %0d got %0d", $time,
                   want.status, rsp_o.status);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > MaxCyc) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [31:0]   pool [8];
    int            kind, fill;
    erp_pkg::rsp_t none;
    err_cnt = 0; cyc_cnt = 0; tbl_cnt = 0; no_idle = 0;
    n_load = 0; n_pick = 0; n_full = 0; n_miss = 0;
    start_i = 1'b0;
    req_i   = '0;
    none    = '0;
    rst_ni  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: empty pick, extremes, duplicates, ignored flag on pick
    add_row(mk_req(erp_pkg::ModePick, 32'h0, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusNotFound));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h8000_0000, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h5, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h5, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModeLoad, 32'hFFFF_FFFF, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h5, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModePick, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModePick, 32'h8000_0000, 31'h0, 1'b1), 1,
            mk_rsp(10'd1, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModePick, 32'h5, 31'h0, 1'b0), 0, none);
    add_row(mk_req(erp_pkg::ModePick, 32'h5, 31'h1, 1'b0), 0, none);
    add_row(mk_req(erp_pkg::ModePick, 32'h5, 31'h7FFF_FFFF, 1'b0), 0, none);
    add_row(mk_req(erp_pkg::ModePick, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b0), 0, none);
    add_row(mk_req(erp_pkg::ModePick, 32'h6, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusNotFound));
    add_row(mk_req(erp_pkg::ModeLoad, 32'h1234, 31'h0, 1'b1), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    add_row(mk_req(erp_pkg::ModePick, 32'h5, 31'h0, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusNotFound));
    add_row(mk_req(erp_pkg::ModePick, 32'h1234, 31'h5555_5555, 1'b0), 1,
            mk_rsp(10'd0, erp_pkg::StatusOk));
    foreach (rows[i]) send_cmd(rows[i].req, rows[i].chk, rows[i].rsp);

    // random part: short load bursts mostly from a small value pool, mixed with picks
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    for (int i = 0; i < NumRand; i++) begin
      if (i > NumRand - 60) no_idle = 1;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        fill = $urandom_range(1, 12);
        for (int j = 0; j < fill; j++)
          send_cmd(mk_req(erp_pkg::ModeLoad, ($urandom_range(0, 4) == 0) ? $urandom :
                          pool[$urandom_range(0, 7)], 31'($urandom), j == 0), 0, none);
        i += fill - 1;
      end else if (kind < 9) begin
        send_cmd(mk_req(erp_pkg::ModePick, ($urandom_range(0, 5) == 0) ? $urandom :
                        pool[$urandom_range(0, 7)], 31'($urandom), 1'($urandom)), 0, none);
      end else begin
        send_cmd(mk_req(erp_pkg::ModeLoad, $urandom, 31'($urandom), 1'($urandom)), 0, none);
      end
    end
    start_i <= 1'b0;

    // drain
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d loads (%0d dropped full) and %0d picks (%0d not found)",
             n_load, n_full, n_pick, n_miss);
    $display("signed extremes, duplicate runs and the first flag on picks exercised");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
